@@ hw/rtl/hits_pkg.sv @@
// Shared types and constants for the heap indexed tree store.
package hits_pkg;

    // Node slots 1 .. CAPACITY-1 hold bytes, slot 0 is never used
    localparam int CAPACITY = 64;
    localparam int NODE_W   = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 8;

    // Stream widths
    localparam int IN_DATA_W  = BYTE_W + 2 * IDX_W;
    localparam int FUNC_W     = 2;
    localparam int OUT_DATA_W = BYTE_W;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_DUMP  = 2'd2,
        FUNC_QUERY = 2'd3
    } hits_func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } hits_status_t;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        hits_func_t          func;
        logic [BYTE_W-1:0]   load_byte;
        logic [NODE_W-1:0]   index_a;
        logic [NODE_W-1:0]   index_b;
        logic                bad_index;
    } hits_req_t;

endpackage

@@ hw/rtl/hits_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hits_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/hits_front.sv @@
// Front end: accepts requests, range-checks query indices, queues them.
module hits_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hits_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [hits_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          q_valid,
    output hits_pkg::hits_req_t           q_req,
    input  logic                          q_pop
);
    import hits_pkg::*;

    localparam int QDEPTH = 2;

    hits_req_t         q_mem_reg [QDEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    hits_req_t         req_in;

    // Classify the incoming request
    always_comb
    begin
        idx_a = s_tdata[BYTE_W +: IDX_W];
        idx_b = s_tdata[BYTE_W + IDX_W +: IDX_W];
        req_in.func      = hits_func_t'(s_tuser);
        req_in.load_byte = s_tdata[BYTE_W-1:0];
        req_in.index_a   = idx_a[NODE_W-1:0];
        req_in.index_b   = idx_b[NODE_W-1:0];
        req_in.bad_index = (idx_a == '0) || (idx_b == '0)
                        || (idx_a >= IDX_W'(CAPACITY)) || (idx_b >= IDX_W'(CAPACITY));
    end

    assign s_tready = (count_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_req    = q_mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("request queue count out of range");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");
`endif

endmodule

@@ hw/rtl/hits_back.sv @@
// Back end: carries out clear, load, ancestor query and preorder dump.
module hits_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  hits_pkg::hits_req_t            q_req,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hits_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [hits_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import hits_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_READ,
        S_DATA,
        S_WALK,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    hits_func_t          func_reg, func_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [NODE_W-1:0]   w_reg, w_next;
    logic [BYTE_W-1:0]   res_val_reg, res_val_next;
    hits_status_t        res_st_reg, res_st_next;
    logic                res_last_reg, res_last_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_val_reg, out_val_next;
    hits_status_t        out_st_reg, out_st_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic                ram_wr_en;
    logic [NODE_W-1:0]   ram_wr_addr;
    logic                ram_rd_en;
    logic [BYTE_W-1:0]   ram_rd_data;

    hits_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(q_req.load_byte),
        .rd_en  (ram_rd_en),
        .rd_addr(a_reg),
        .rd_data(ram_rd_data)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign ram_wr_addr = fill_reg[NODE_W-1:0];
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_val_reg;
    assign m_tuser     = out_st_reg;
    assign m_tlast     = out_last_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        func_next     = func_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        w_next        = w_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        res_last_next = res_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next  = out_val_reg;
        out_st_next   = out_st_reg;
        out_last_next = out_last_reg;
        q_pop         = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    func_next     = q_req.func;
                    res_val_next  = '0;
                    res_st_next   = ST_OK;
                    res_last_next = 1'b1;
                    state_next    = S_EMIT;
                    unique case (q_req.func)
                        FUNC_CLEAR:
                        begin
                            fill_next = FILL_W'(1);
                        end
                        FUNC_LOAD:
                        begin
                            if (fill_reg == FILL_W'(CAPACITY))
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (fill_reg <= FILL_W'(1))
                            begin
                                res_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                a_next     = NODE_W'(1);
                                state_next = S_READ;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (q_req.bad_index)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                a_next     = q_req.index_a;
                                b_next     = q_req.index_b;
                                state_next = S_QUERY;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Halve the larger index until both meet
            S_QUERY:
            begin
                if (a_reg == b_reg)
                begin
                    state_next = S_READ;
                end
                else if (a_reg > b_reg)
                begin
                    a_next = a_reg >> 1;
                end
                else
                begin
                    b_next = b_reg >> 1;
                end
            end

            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_DATA;
            end

            // Nodes at or past the fill mark read as zero
            S_DATA:
            begin
                res_val_next = ({1'b0, a_reg} < fill_reg) ? ram_rd_data : '0;
                res_st_next  = ST_OK;
                if (func_reg == FUNC_QUERY)
                begin
                    res_last_next = 1'b1;
                    state_next    = S_EMIT;
                end
                else if ({a_reg, 1'b0} < fill_reg)
                begin
                    // left child exists: it comes next
                    b_next        = NODE_W'({a_reg, 1'b0});
                    res_last_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    w_next     = a_reg;
                    state_next = S_WALK;
                end
            end

            // Climb until a right sibling exists; the root ends the dump
            S_WALK:
            begin
                if (w_reg == NODE_W'(1))
                begin
                    res_last_next = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (!w_reg[0] && (({1'b0, w_reg} + FILL_W'(1)) < fill_reg))
                begin
                    b_next        = w_reg + NODE_W'(1);
                    res_last_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    w_next = w_reg >> 1;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    out_last_next  = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        a_next     = b_reg;
                        state_next = S_READ;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= FILL_W'(1);
            out_valid_reg <= 1'b0;
            res_last_reg  <= 1'b0;
            func_reg      <= FUNC_CLEAR;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            res_last_reg  <= res_last_next;
            func_reg      <= func_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        w_reg       <= w_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= FILL_W'(1)) && (fill_reg <= FILL_W'(CAPACITY)))
        else $error("fill mark out of range");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (fill_reg < FILL_W'(CAPACITY)))
        else $error("store written past capacity");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("request taken while busy");
    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (w_reg != '0))
        else $error("preorder walk climbed past the root");
    a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> ($past(state_reg) == S_READ))
        else $error("read data used without a read");
`endif

endmodule

@@ hw/rtl/heap_indexed_tree_store_core.sv @@
// Top level of the heap indexed tree store: request queue front end and execution back end.
//
// A byte store laid out as an implicit binary tree (root 1, children 2k and
// 2k+1) with slots 1 .. CAPACITY-1 filled in breadth-first order. Requests on
// the slave stream are queued two deep, so the sender can run ahead while a
// long request executes. An ancestor query halves the larger index until both
// meet, at most 2*(log2(CAPACITY)-1) steps. A preorder dump reads each node
// and moves on to its left child; failing that, it climbs back one level per
// cycle to find a right sibling. The single store read port paces the dump,
// and a stalled master side holds it further. Every request gives at least one
// result and the final one carries tlast. There is no clearing pass: a fill
// mark decides which slots hold data, unfilled slots read as zero.
module heap_indexed_tree_store_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_byte[7:0], index_a[15:8], index_b[23:16]
    input  logic [hits_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [hits_pkg::FUNC_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value[7:0]
    output logic [hits_pkg::OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [hits_pkg::STATUS_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import hits_pkg::*;

    logic      q_valid;
    logic      q_pop;
    hits_req_t q_req;

    hits_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    hits_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
